// File: hw/rtl/lmr_pkg.sv
package lmr_pkg;

  localparam int BYTE_W     = 8;
  localparam int TAG_W      = 5;
  localparam int BOUNDARY_W = 16;
  localparam int MIN_W      = 16;
  localparam int LEN_FIELD_W = 7;

  localparam logic [BYTE_W-1:0] SEQUENCE_TAG    = 8'h30;
  localparam logic [TAG_W-1:0]  INTEGER_TAG_NUM = 5'h02;
  localparam logic [BYTE_W-1:0] RESULT_CODE_TAG = 8'h02;
  localparam logic [1:0]        APP_CLASS       = 2'b01;
  localparam logic [TAG_W-1:0]  MAX_OP_TAG      = 5'd25;
  localparam logic [MIN_W-1:0]  MIN_MESSAGE_LEN = 16'd7;
  localparam logic [LEN_FIELD_W-1:0] MAX_ID_LEN = 7'd4;
  localparam logic [MIN_W-1:0]  RESULT_TAG_LEN  = 16'd2;

  typedef struct packed {
    logic             is_ldap;
    logic [TAG_W-1:0] operation_tag;
  } verdict_t;

endpackage

// File: hw/rtl/lmr_in_if.sv
interface lmr_in_if;
  logic                              valid;
  logic                              ready;
  logic [lmr_pkg::BYTE_W-1:0]        data_byte;
  logic                              last_byte;
  logic [lmr_pkg::BOUNDARY_W-1:0]    boundary_length;

  modport source (output valid, output data_byte, output last_byte,
                  output boundary_length, input ready);
  modport sink (input valid, input data_byte, input last_byte,
                input boundary_length, output ready);
endinterface

// File: hw/rtl/lmr_out_if.sv
interface lmr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        is_ldap;
  logic [lmr_pkg::TAG_W-1:0]   operation_tag;

  modport source (output valid, output is_ldap, output operation_tag, input ready);
  modport sink (input valid, input is_ldap, input operation_tag, output ready);
endinterface

// File: hw/rtl/lmr_parser.sv
module lmr_parser #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [lmr_pkg::BYTE_W-1:0]      data_byte,
  input  logic                            last_byte,
  input  logic [lmr_pkg::BOUNDARY_W-1:0]  boundary_length,
  output lmr_pkg::verdict_t               verdict
);
  import lmr_pkg::*;

  localparam int CMP_W = (LENGTH_BITS + 1 > BOUNDARY_W + 1) ? LENGTH_BITS + 1 : BOUNDARY_W + 1;
  localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

  typedef enum logic [3:0] {
    PH_SEQ_TAG, PH_SEQ_LEN, PH_ID_TAG, PH_ID_LEN,
    PH_OP_TAG, PH_OP_LEN, PH_RESULT_TAG, PH_DONE
  } phase_t;

  phase_t                  parse_phase, phase_next;
  logic [LENGTH_BITS-1:0]  byte_position;
  logic [LENGTH_BITS-1:0]  next_field_position, nfp_next;
  logic [MIN_W-1:0]        running_minimum, rmin_next;
  logic [MIN_W-1:0]        required_length, req_next;
  logic [BOUNDARY_W-1:0]   boundary_store, boundary_eff;
  logic [TAG_W-1:0]        op_tag_store, op_tag_next;
  logic                    rejected, rejected_next;

  logic [LEN_FIELD_W-1:0]  len;
  logic                    longform;
  logic [LENGTH_BITS:0]    field_end;
  logic [LENGTH_BITS-1:0]  field_end_sat;
  logic [LENGTH_BITS-1:0]  pos_inc;
  logic                    field_reached;
  logic [MIN_W-1:0]        rmin_a, rmin_b, req_a;
  logic [CMP_W-1:0]        total, pkt, bnd_wide;
  logic                    ok;

  assign len      = data_byte[LEN_FIELD_W-1:0];
  assign longform = data_byte[BYTE_W-1];
  assign boundary_eff = (byte_position == '0) ? boundary_length : boundary_store;
  assign field_end = {1'b0, byte_position} + (LENGTH_BITS+1)'(len) + (LENGTH_BITS+1)'(1);
  assign field_end_sat = field_end[LENGTH_BITS] ? POS_MAX : field_end[LENGTH_BITS-1:0];
  assign pos_inc = (byte_position == POS_MAX) ? POS_MAX : byte_position + LENGTH_BITS'(1);
  assign field_reached = byte_position >= next_field_position;

  always_comb begin
    phase_next    = parse_phase;
    nfp_next      = next_field_position;
    rmin_next     = running_minimum;
    req_next      = required_length;
    op_tag_next   = op_tag_store;
    rejected_next = rejected;
    rmin_a        = '0;
    rmin_b        = '0;
    req_a         = '0;
    unique case (parse_phase)
      PH_SEQ_TAG: begin
        if (data_byte != SEQUENCE_TAG) begin
          rejected_next = 1'b1;
          phase_next    = PH_DONE;
        end else begin
          phase_next = PH_SEQ_LEN;
        end
      end
      PH_SEQ_LEN: begin
        if (longform) begin
          rmin_next = MIN_MESSAGE_LEN + MIN_W'(len);
          req_next  = MIN_MESSAGE_LEN + MIN_W'(len);
          nfp_next  = field_end_sat;
        end else begin
          rmin_next = MIN_MESSAGE_LEN;
          req_next  = '0;
          nfp_next  = pos_inc;
        end
        phase_next = PH_ID_TAG;
      end
      PH_ID_TAG: begin
        if (field_reached) begin
          if (data_byte[TAG_W-1:0] != INTEGER_TAG_NUM) begin
            rejected_next = 1'b1;
            phase_next    = PH_DONE;
          end else begin
            phase_next = PH_ID_LEN;
          end
        end
      end
      PH_ID_LEN: begin
        if (len > MAX_ID_LEN) begin
          rejected_next = 1'b1;
          phase_next    = PH_DONE;
        end else begin
          nfp_next   = field_end_sat;
          rmin_a     = running_minimum + MIN_W'(len) - MIN_W'(1);
          rmin_next  = rmin_a;
          req_next   = (rmin_a > required_length) ? rmin_a : required_length;
          phase_next = PH_OP_TAG;
        end
      end
      PH_OP_TAG: begin
        if (field_reached) begin
          if (data_byte[BYTE_W-1:BYTE_W-2] != APP_CLASS ||
              data_byte[TAG_W-1:0] > MAX_OP_TAG) begin
            rejected_next = 1'b1;
            phase_next    = PH_DONE;
          end else begin
            op_tag_next = data_byte[TAG_W-1:0];
            phase_next  = PH_OP_LEN;
          end
        end
      end
      PH_OP_LEN: begin
        if (longform) begin
          phase_next = PH_DONE;
        end else begin
          nfp_next = field_end_sat;
          rmin_a   = running_minimum + MIN_W'(len);
          req_a    = (rmin_a > required_length) ? rmin_a : required_length;
          if (op_tag_store[0]) begin
            rmin_b     = rmin_a + RESULT_TAG_LEN;
            rmin_next  = rmin_b;
            req_next   = (rmin_b > req_a) ? rmin_b : req_a;
            phase_next = PH_RESULT_TAG;
          end else begin
            rmin_next  = rmin_a;
            req_next   = req_a;
            phase_next = PH_DONE;
          end
        end
      end
      PH_RESULT_TAG: begin
        if (field_reached) begin
          if (data_byte != RESULT_CODE_TAG) begin
            rejected_next = 1'b1;
          end
          phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  assign total    = CMP_W'(byte_position) + CMP_W'(1);
  assign bnd_wide = CMP_W'(boundary_eff);
  assign pkt = (boundary_eff != '0 && bnd_wide < total) ? bnd_wide : total;
  assign ok = (phase_next == PH_DONE) && !rejected_next &&
              (total >= CMP_W'(MIN_MESSAGE_LEN)) && (pkt >= CMP_W'(req_next));

  assign verdict.is_ldap       = ok;
  assign verdict.operation_tag = ok ? op_tag_next : '0;

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_position       <= '0;
      parse_phase         <= PH_SEQ_TAG;
      next_field_position <= '0;
      running_minimum     <= MIN_MESSAGE_LEN;
      required_length     <= MIN_MESSAGE_LEN;
      boundary_store      <= '0;
      op_tag_store        <= '0;
      rejected            <= 1'b0;
    end else if (step) begin
      byte_position       <= pos_inc;
      parse_phase         <= phase_next;
      next_field_position <= nfp_next;
      running_minimum     <= rmin_next;
      required_length     <= req_next;
      boundary_store      <= boundary_eff;
      op_tag_store        <= op_tag_next;
      rejected            <= rejected_next;
    end
  end

endmodule

// File: hw/rtl/ldap_message_recognizer.sv
// An accepted byte waits in the input register until it is parsed; the verdict
// on a byte marked last is registered in the output register once parsed.
// Throughput: one payload byte per cycle, set by the single parse stage,
// while no verdict waits for ready. Reset (rst, synchronous) empties both
// registers and restarts the parser; one verdict follows each last byte.
module ldap_message_recognizer #(
  parameter int LENGTH_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  lmr_in_if.sink    payload,
  lmr_out_if.source verdict
);
  import lmr_pkg::*;

  logic                  held_valid;
  logic [BYTE_W-1:0]     held_byte;
  logic                  held_last;
  logic [BOUNDARY_W-1:0] held_boundary;
  logic                  advance;
  logic                  out_valid;
  verdict_t              out_verdict;
  verdict_t              step_verdict;

  assign advance       = held_valid && (!held_last || !out_valid || verdict.ready);
  assign payload.ready = !held_valid || advance;

  lmr_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .data_byte       (held_byte),
    .last_byte       (held_last),
    .boundary_length (held_boundary),
    .verdict         (step_verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (payload.ready) begin
      held_valid <= payload.valid;
    end
    if (payload.valid && payload.ready) begin
      held_byte     <= payload.data_byte;
      held_last     <= payload.last_byte;
      held_boundary <= payload.boundary_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && held_last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && held_last) begin
      out_verdict <= step_verdict;
    end
  end

  assign verdict.valid         = out_valid;
  assign verdict.is_ldap       = out_verdict.is_ldap;
  assign verdict.operation_tag = out_verdict.operation_tag;

endmodule

// File: hw/rtl/lmr_checker.sv
module lmr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       is_ldap,
  input logic [lmr_pkg::TAG_W-1:0]  operation_tag
);
  import lmr_pkg::*;

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_ldap) && $stable(operation_tag))
    else $error("stalled verdict changed");

  a_reject_no_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_ldap |-> operation_tag == '0)
    else $error("rejected verdict carries a tag");

  a_tag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> operation_tag <= MAX_OP_TAG)
    else $error("operation tag out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("verdict presented after reset");

endmodule

bind ldap_message_recognizer lmr_checker u_lmr_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (verdict.valid),
  .out_ready     (verdict.ready),
  .is_ldap       (verdict.is_ldap),
  .operation_tag (verdict.operation_tag)
);
